FILE: hw/rtl/scsa_pkg.sv
package scsa_pkg;

    localparam int MIN_SHIFT       = 8;
    localparam int MAX_SHIFT       = 27;
    localparam int NUM_CLASSES     = 20;
    localparam int SLOTS_PER_CLASS = 16;

    localparam int SIZE_W   = 36;
    localparam int BYTES_W  = 48;
    localparam int CLASS_W  = 5;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 2;
    localparam int MSB_W    = $clog2(SIZE_W);

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_ALLOC = 2'd2;

    localparam logic ACTION_ALLOC = 1'b0;
    localparam logic ACTION_FREE  = 1'b1;

    typedef logic [SLOTS_PER_CLASS-1:0] bitmap_t;

    // Byte accounting update, committed when a word leaves the execute stage
    typedef struct packed {
        logic              commit;
        logic              alloc_ok;
        logic              is_free;
        logic [SIZE_W-1:0] size;
    } acct_upd_t;

endpackage

FILE: hw/rtl/size_class_slot_allocator.sv
// Size-class slot allocator. Each request word allocates (action 0) or frees
// (action 1) a slot in the power-of-two size class picked from req_bytes,
// and returns one response word with the status, class, slot and the running
// and peak byte totals. The response register loads when the execute step
// commits: the accepting edge starts the synchronous read of the class bitmap
// memory, and the execute step then picks or clears the slot, writes the
// bitmap back and updates the byte counters. Requests are handled one at a
// time, so a new request is not taken until the last one has committed;
// req_ready stays low while a request is in the execute step or waits for
// the response register.
module size_class_slot_allocator
    import scsa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic                action,
    input  logic [SIZE_W-1:0]   req_bytes,
    input  logic [SLOT_W-1:0]   free_slot,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic [STATUS_W-1:0] status,
    output logic [CLASS_W-1:0]  size_class,
    output logic [SLOT_W-1:0]   granted_slot,
    output logic [BYTES_W-1:0]  bytes_in_use,
    output logic [BYTES_W-1:0]  peak_bytes
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    logic               action_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [SLOT_W-1:0]  slot_in_reg;
    logic [CLASS_W-1:0] class_reg;

    logic                rsp_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [CLASS_W-1:0]  class_out_reg;
    logic [SLOT_W-1:0]   slot_out_reg;
    logic [BYTES_W-1:0]  bytes_reg;
    logic [BYTES_W-1:0]  peak_reg;

    logic               accept;
    logic               commit;
    logic [CLASS_W-1:0] class_sel;
    bitmap_t            rd_bitmap;
    bitmap_t            free_bits;
    bitmap_t            wr_bitmap;
    logic               wr_en;
    logic [SLOT_W-1:0]  low_free;
    logic               slot_used;
    logic [STATUS_W-1:0] status_calc;
    logic [SLOT_W-1:0]  slot_calc;
    acct_upd_t          acct_upd;
    logic [BYTES_W-1:0] total_next;
    logic [BYTES_W-1:0] peak_next;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign commit    = (state_reg == ST_EXEC) && (!rsp_valid_reg || rsp_ready);

    scsa_class_sel u_class_sel (
        .req_bytes  (req_bytes),
        .size_class (class_sel)
    );

    scsa_bitmap_mem u_bitmap_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (class_sel),
        .rd_data (rd_bitmap),
        .wr_en   (wr_en),
        .wr_addr (class_reg),
        .wr_data (wr_bitmap)
    );

    assign free_bits = ~rd_bitmap;

    // Lowest free slot
    always_comb
    begin
        low_free = '0;
        for (int i = SLOTS_PER_CLASS - 1; i >= 0; i--)
        begin
            if (free_bits[i])
                low_free = SLOT_W'(i);
        end
    end

    assign slot_used = (32'(slot_in_reg) < SLOTS_PER_CLASS) && rd_bitmap[slot_in_reg];

    always_comb
    begin
        status_calc = STATUS_OK;
        slot_calc   = '0;
        wr_bitmap   = rd_bitmap;
        wr_en       = 1'b0;
        if (action_reg == ACTION_ALLOC)
        begin
            if (free_bits == '0)
                status_calc = STATUS_NO_SPACE;
            else
            begin
                slot_calc            = low_free;
                wr_bitmap[low_free]  = 1'b1;
                wr_en                = commit;
            end
        end
        else
        begin
            slot_calc = slot_in_reg;
            if (slot_used)
            begin
                wr_bitmap[slot_in_reg] = 1'b0;
                wr_en                  = commit;
            end
            else
                status_calc = STATUS_NOT_ALLOC;
        end
    end

    always_comb
    begin
        acct_upd.commit   = commit;
        acct_upd.alloc_ok = (action_reg == ACTION_ALLOC) && (status_calc == STATUS_OK);
        acct_upd.is_free  = (action_reg == ACTION_FREE);
        acct_upd.size     = size_reg;
    end

    scsa_byte_acct u_byte_acct (
        .clk        (clk),
        .rst_n      (rst_n),
        .upd        (acct_upd),
        .total_next (total_next),
        .peak_next  (peak_next)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                // Hold the read word until the response register frees up
                if (commit)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg  <= action;
            size_reg    <= req_bytes;
            slot_in_reg <= free_slot;
            class_reg   <= class_sel;
        end
        if (commit)
        begin
            status_reg    <= status_calc;
            class_out_reg <= class_reg;
            slot_out_reg  <= slot_calc;
            bytes_reg     <= total_next;
            peak_reg      <= peak_next;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_reg;
    assign size_class   = class_out_reg;
    assign granted_slot = slot_out_reg;
    assign bytes_in_use = bytes_reg;
    assign peak_bytes   = peak_reg;

`ifndef SYNTHESIS
    a_accept_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EXEC) && !req_ready)
        else $error("accepted word did not enter execute step");

    a_peak_covers_total: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (peak_bytes >= bytes_in_use))
        else $error("peak below bytes in use");

    a_no_space_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == STATUS_NO_SPACE)) |-> (granted_slot == '0))
        else $error("slot given on a full class");

    a_write_only_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> commit && (state_reg == ST_EXEC))
        else $error("bitmap written outside execute step");
`endif

endmodule

FILE: hw/rtl/scsa_class_sel.sv
module scsa_class_sel
    import scsa_pkg::*;
(
    input  logic [SIZE_W-1:0]  req_bytes,
    output logic [CLASS_W-1:0] size_class
);

    logic [SIZE_W-1:0] size_m1;
    logic [MSB_W-1:0]  msb;
    logic [MSB_W:0]    raw_class;

    assign size_m1 = req_bytes - SIZE_W'(1);

    // Leading-one position of size-1 gives floor(log2(size-1)); ceil(log2 size) is one more
    always_comb
    begin
        msb = '0;
        for (int i = 0; i < SIZE_W; i++)
        begin
            if (size_m1[i])
                msb = MSB_W'(i);
        end
    end

    assign raw_class = (MSB_W+1)'(msb) + (MSB_W+1)'(1) - (MSB_W+1)'(MIN_SHIFT);

    always_comb
    begin
        if (req_bytes <= SIZE_W'(64'd1 << MIN_SHIFT))
            size_class = '0;
        else if (req_bytes > SIZE_W'(64'd1 << MAX_SHIFT))
            size_class = CLASS_W'(NUM_CLASSES - 1);
        else if (raw_class > (MSB_W+1)'(NUM_CLASSES - 1))
            size_class = CLASS_W'(NUM_CLASSES - 1);
        else
            size_class = CLASS_W'(raw_class);
    end

endmodule

FILE: hw/rtl/scsa_bitmap_mem.sv
module scsa_bitmap_mem
    import scsa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rd_en,
    input  logic [CLASS_W-1:0] rd_addr,
    output bitmap_t            rd_data,
    input  logic               wr_en,
    input  logic [CLASS_W-1:0] wr_addr,
    input  bitmap_t            wr_data
);

    bitmap_t                mem [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] written_reg;
    bitmap_t                rd_data_reg;
    logic                   rd_written_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // Entries never written read as all slots free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                written_reg[wr_addr] <= 1'b1;
            if (rd_en)
                rd_written_reg <= written_reg[rd_addr];
        end
    end

    assign rd_data = rd_written_reg ? rd_data_reg : '0;

endmodule

FILE: hw/rtl/scsa_byte_acct.sv
module scsa_byte_acct
    import scsa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  acct_upd_t          upd,
    output logic [BYTES_W-1:0] total_next,
    output logic [BYTES_W-1:0] peak_next
);

    logic [BYTES_W-1:0] total_reg;
    logic [BYTES_W-1:0] peak_reg;
    logic [BYTES_W:0]   sum;
    logic [BYTES_W-1:0] size_ext;

    assign size_ext = BYTES_W'(upd.size);
    assign sum      = {1'b0, total_reg} + {1'b0, size_ext};

    always_comb
    begin
        total_next = total_reg;
        peak_next  = peak_reg;
        if (upd.alloc_ok)
        begin
            // Saturate at the top of the counter
            total_next = sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];
            if (total_next > peak_reg)
                peak_next = total_next;
        end
        else if (upd.is_free)
        begin
            // Saturate at zero
            total_next = (size_ext > total_reg) ? '0 : total_reg - size_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            peak_reg  <= '0;
        end
        else if (upd.commit)
        begin
            total_reg <= total_next;
            peak_reg  <= peak_next;
        end
    end

endmodule

FILE: tb/sv/tb_size_class_slot_allocator.sv
module tb_size_class_slot_allocator;
    import scsa_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam logic [SIZE_W-1:0]  SIZE_TOP  = '1;
    localparam logic [BYTES_W-1:0] BYTES_TOP = '1;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [CLASS_W-1:0]  cls;
        logic [SLOT_W-1:0]   slot;
        logic [BYTES_W-1:0]  bytes;
        logic [BYTES_W-1:0]  peak;
    } grant_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    logic                action = ACTION_ALLOC;
    logic [SIZE_W-1:0]   req_bytes = '0;
    logic [SLOT_W-1:0]   free_slot = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [CLASS_W-1:0]  size_class;
    logic [SLOT_W-1:0]   granted_slot;
    logic [BYTES_W-1:0]  bytes_in_use;
    logic [BYTES_W-1:0]  peak_bytes;

    // Own copy of the allocator state
    bitmap_t             slot_map [NUM_CLASSES];
    logic [BYTES_W-1:0]  live_bytes = '0;
    logic [BYTES_W-1:0]  live_peak = '0;
    grant_t              pending_grants [$];

    int send_idle_pct = 34;
    int recv_idle_pct = 45;
    int mismatch_count = 0;
    int stall_cycles = 0;

    size_class_slot_allocator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .action       (action),
        .req_bytes    (req_bytes),
        .free_slot    (free_slot),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .status       (status),
        .size_class   (size_class),
        .granted_slot (granted_slot),
        .bytes_in_use (bytes_in_use),
        .peak_bytes   (peak_bytes)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [CLASS_W-1:0] class_of_size(input logic [SIZE_W-1:0] size);
        int c;
        c = 0;
        if (size <= (64'd1 << MIN_SHIFT))
            return CLASS_W'(0);
        if (size > (64'd1 << MAX_SHIFT))
            return CLASS_W'(NUM_CLASSES - 1);
        while ((64'd1 << c) < size)
            c++;
        if (c - MIN_SHIFT > NUM_CLASSES - 1)
            return CLASS_W'(NUM_CLASSES - 1);
        return CLASS_W'(c - MIN_SHIFT);
    endfunction

    // Random size that lands in the given class
    function automatic logic [SIZE_W-1:0] size_in_class(input int c);
        logic [63:0] lo;
        logic [63:0] span;
        logic [63:0] r;
        if (c == 0)
            return SIZE_W'($urandom_range(1 << MIN_SHIFT));
        lo = (64'd1 << (c + MIN_SHIFT - 1)) + 64'd1;
        if (c == NUM_CLASSES - 1)
            span = {28'd0, SIZE_TOP} - lo + 64'd1;
        else
            span = (64'd1 << (c + MIN_SHIFT)) - lo + 64'd1;
        r = {$urandom, $urandom};
        return SIZE_W'(lo + r % span);
    endfunction

    task automatic predict_grant(input logic act, input logic [SIZE_W-1:0] size,
                                 input logic [SLOT_W-1:0] slot_in);
        grant_t             g;
        logic [BYTES_W-1:0] size_b;
        int                 s;
        size_b   = BYTES_W'(size);
        g.status = STATUS_OK;
        g.cls    = class_of_size(size);
        g.slot   = '0;
        if (act == ACTION_ALLOC)
        begin
            if (&slot_map[g.cls])
                g.status = STATUS_NO_SPACE;
            else
            begin
                for (s = SLOTS_PER_CLASS - 1; s >= 0; s--)
                    if (!slot_map[g.cls][s])
                        g.slot = SLOT_W'(s);
                slot_map[g.cls][g.slot] = 1'b1;
                if (size_b > BYTES_TOP - live_bytes)
                    live_bytes = BYTES_TOP;
                else
                    live_bytes = live_bytes + size_b;
                if (live_bytes > live_peak)
                    live_peak = live_bytes;
            end
        end
        else
        begin
            g.slot = slot_in;
            if (slot_map[g.cls][slot_in])
                slot_map[g.cls][slot_in] = 1'b0;
            else
                g.status = STATUS_NOT_ALLOC;
            // Subtract even on a bad free; floor at zero
            if (size_b > live_bytes)
                live_bytes = '0;
            else
                live_bytes = live_bytes - size_b;
        end
        g.bytes = live_bytes;
        g.peak  = live_peak;
        pending_grants.insert(pending_grants.size(), g);
    endtask

    // Enter at a rising edge; return at the edge where the word is taken
    task automatic send_request(input logic act, input logic [SIZE_W-1:0] size,
                                input logic [SLOT_W-1:0] slot_in);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        action    <= act;
        req_bytes <= size;
        free_slot <= slot_in;
        do
            @(posedge clk);
        while (!req_ready);
        predict_grant(act, size, slot_in);
    endtask

    function automatic void check_field(input string name, input logic [BYTES_W-1:0] want,
                                        input logic [BYTES_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t %s: expected %0h actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        grant_t g;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_grants.size() == 0)
            begin
                $display("%0t unexpected word: expected none actual status %0h class %0d",
                         $time, status, size_class);
                mismatch_count++;
            end
            else
            begin
                g = pending_grants.pop_front();
                check_field("status", BYTES_W'(g.status), BYTES_W'(status));
                check_field("size_class", BYTES_W'(g.cls), BYTES_W'(size_class));
                check_field("granted_slot", BYTES_W'(g.slot), BYTES_W'(granted_slot));
                check_field("bytes_in_use", g.bytes, bytes_in_use);
                check_field("peak_bytes", g.peak, peak_bytes);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Free before anything is held: not allocated, total floors at zero
    task automatic test_free_underflow();
        send_request(ACTION_FREE, SIZE_W'(300), SLOT_W'(0));
    endtask

    task automatic test_class_boundaries();
        send_request(ACTION_ALLOC, SIZE_W'(0), '0);
        send_request(ACTION_ALLOC, SIZE_W'(256), '0);
        send_request(ACTION_ALLOC, SIZE_W'(257), '0);
        send_request(ACTION_ALLOC, SIZE_W'(512), '0);
        send_request(ACTION_ALLOC, SIZE_W'(513), '0);
        send_request(ACTION_ALLOC, SIZE_W'(64'd1 << 26), '0);
        send_request(ACTION_ALLOC, SIZE_W'((64'd1 << 26) + 1), '0);
        send_request(ACTION_ALLOC, SIZE_W'((64'd1 << 27) + 1), '1);
        send_request(ACTION_ALLOC, SIZE_TOP, '1);
    endtask

    // Fill the top class, then one more allocate must be refused
    task automatic test_class_full();
        repeat (SLOTS_PER_CLASS - 3)
            send_request(ACTION_ALLOC, SIZE_TOP, '0);
        send_request(ACTION_ALLOC, SIZE_TOP, '1);
    endtask

    task automatic test_double_free();
        send_request(ACTION_FREE, SIZE_TOP, SLOT_W'(5));
        send_request(ACTION_FREE, SIZE_TOP, SLOT_W'(5));
    endtask

    task automatic test_random_traffic(input int n_items);
        int                cls;
        int                pick;
        logic              act;
        logic [SIZE_W-1:0] size;
        logic [SLOT_W-1:0] slot_in;
        repeat (n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                cls = -1;
            else if (pick < 70)
                cls = ($urandom_range(1) == 0) ? int'($urandom_range(2)) : NUM_CLASSES - 1;
            else
                cls = int'($urandom_range(NUM_CLASSES - 1));
            if (cls < 0)
            begin
                size = SIZE_W'({$urandom, $urandom});
                cls  = int'(class_of_size(size));
            end
            else
                size = size_in_class(cls);
            act     = ($urandom_range(99) < 55) ? ACTION_ALLOC : ACTION_FREE;
            slot_in = SLOT_W'($urandom);
            // Mostly free a slot that is actually held
            if (act == ACTION_FREE && slot_map[cls] != '0 && $urandom_range(99) < 80)
                while (!slot_map[cls][slot_in])
                    slot_in = SLOT_W'($urandom);
            send_request(act, size, slot_in);
        end
    endtask

    initial
    begin
        foreach (slot_map[i])
            slot_map[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_free_underflow();
        test_class_boundaries();
        test_class_full();
        test_double_free();
        test_random_traffic(300);

        send_idle_pct = 45;
        recv_idle_pct = 34;
        test_random_traffic(300);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(300);

        req_valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
